// File: src/integer_to_radix_ascii_core_macros.svh
// Assertion helpers used by the top-level RTL.
`ifndef INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// ante holds in a cycle -> cons holds in the same cycle
`define ITOA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// ante holds in a cycle -> cons holds in the next cycle
`define ITOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ITOA_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ITOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: src/itoa_pkg.sv
package itoa_pkg;

	localparam int NUM_BITS    = 64;
	localparam int NARROW_BITS = 32;

	localparam logic [5:0] RADIX_MIN = 6'd2;
	localparam logic [5:0] RADIX_MAX = 6'd36;
	localparam logic [5:0] RADIX_DEC = 6'd10;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h61;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_NONE  = 8'h00;

	// classified item handed from front to back
	typedef struct packed {
		logic [NUM_BITS-1:0] value;  // masked magnitude
		logic [5:0]          radix;
		logic                neg;
		logic                wide;
		logic                bad;
	} cmd_t;

	function automatic logic [7:0] digit_char(input logic [5:0] d);
		logic [7:0] c;
		if (d < RADIX_DEC) begin
			c = CHAR_ZERO + {2'b00, d};
		end else begin
			c = CHAR_A + {2'b00, d} - {2'b00, RADIX_DEC};
		end
		return c;
	endfunction

endpackage

// File: src/itoa_ram.sv
module itoa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/itoa_front.sv
module itoa_front #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [71:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	output itoa_pkg::cmd_t      cmd,
	output logic                cmd_valid,
	input  logic                cmd_ready
);

	localparam logic [itoa_pkg::NUM_BITS-1:0] WIDE_MASK =
		{itoa_pkg::NUM_BITS{1'b1}} >> (itoa_pkg::NUM_BITS - MAX_WIDTH);
	localparam logic [itoa_pkg::NUM_BITS-1:0] NARROW_MASK =
		{itoa_pkg::NUM_BITS{1'b1}} >> (itoa_pkg::NUM_BITS - itoa_pkg::NARROW_BITS);

	logic [5:0]                   radix;
	logic                         bad;
	logic                         wide;
	logic                         sign_bit;
	logic [itoa_pkg::NUM_BITS-1:0] mask;
	logic [itoa_pkg::NUM_BITS-1:0] v;

	assign radix = s_tdata[69:64];
	assign wide  = s_tuser[1];
	assign bad   = (radix < itoa_pkg::RADIX_MIN) || (radix > itoa_pkg::RADIX_MAX);
	assign mask  = wide ? WIDE_MASK : NARROW_MASK;
	assign v     = s_tdata[63:0] & mask;
	assign sign_bit = wide ? v[MAX_WIDTH-1] : v[itoa_pkg::NARROW_BITS-1];

	always_comb begin
		cmd.radix = radix;
		cmd.wide  = wide;
		cmd.bad   = bad;
		// sign only matters for base 10
		cmd.neg   = s_tuser[0] && (radix == itoa_pkg::RADIX_DEC) && sign_bit;
		cmd.value = cmd.neg ? ((~v + 64'd1) & mask) : v;
	end

	assign cmd_valid = s_tvalid;
	assign s_tready  = cmd_ready;

endmodule

// File: src/itoa_queue.sv
module itoa_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  itoa_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output itoa_pkg::cmd_t pop_cmd
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	itoa_pkg::cmd_t  mem_q [DEPTH];
	logic [PW-1:0]   wr_q;
	logic [PW-1:0]   rd_q;
	logic [PW:0]     cnt_q;
	logic            push;
	logic            pop;

	assign push_ready = (cnt_q != (PW+1)'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// File: src/itoa_back.sv
module itoa_back #(
	parameter int MAX_WIDTH = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  itoa_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	output logic [7:0]     m_tdata,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic           m_tlast,
	output logic           m_tuser
);

	localparam int NCHUNK = (MAX_WIDTH + 7) / 8;
	localparam int VW     = NCHUNK * 8;
	localparam int CW     = $clog2(NCHUNK);
	localparam int AW     = $clog2(MAX_WIDTH);
	localparam logic [CW-1:0] TOP_WIDE   = CW'(NCHUNK - 1);
	localparam logic [CW-1:0] TOP_NARROW = CW'(itoa_pkg::NARROW_BITS / 8 - 1);
	localparam logic [AW-1:0] LAST_ADDR  = AW'(MAX_WIDTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_RD,
		ST_OUT,
		ST_ERR
	} state_t;

	state_t          state_q;
	logic [VW-1:0]   v_q;
	logic [5:0]      radix_q;
	logic [5:0]      rem_q;
	logic            neg_q;
	logic [CW-1:0]   top_q;
	logic [CW-1:0]   c_q;
	logic [AW-1:0]   n_q;
	logic [AW-1:0]   idx_q;

	logic [7:0]      byte_in;
	logic [7:0]      q_byte;
	logic [6:0]      t;
	logic [5:0]      r;
	logic [5:0]      rem_nxt;
	logic [VW-1:0]   v_nxt;
	logic            v_zero;
	logic            shrink;
	logic            out_free;
	logic            out_load;

	logic            ram_we;
	logic [7:0]      ram_wdata;
	logic            ram_re;
	logic [AW-1:0]   ram_raddr;
	logic [7:0]      ram_rdata;

	// one quotient byte per cycle, MSB-first restoring division
	always_comb begin
		byte_in = v_q[c_q*8 +: 8];
		r       = rem_q;
		q_byte  = '0;
		t       = '0;
		for (int i = 7; i >= 0; i--) begin
			t = {r, byte_in[i]};
			if (t >= {1'b0, radix_q}) begin
				t         = t - {1'b0, radix_q};
				q_byte[i] = 1'b1;
			end
			r = t[5:0];
		end
		rem_nxt = r;
		v_nxt   = v_q;
		v_nxt[c_q*8 +: 8] = q_byte;
	end

	assign v_zero = (v_nxt == '0);
	// radix < 256, so the quotient loses at most one byte per digit
	assign shrink = (top_q != '0) && (v_nxt[top_q*8 +: 8] == 8'h00);

	assign out_free  = !m_tvalid || m_tready;
	// a new item goes into the output register this cycle
	assign out_load  = out_free &&
		(state_q == ST_SIGN || state_q == ST_OUT || state_q == ST_ERR);
	assign cmd_ready = (state_q == ST_IDLE);

	assign ram_we    = (state_q == ST_DIV) && (c_q == '0);
	assign ram_wdata = itoa_pkg::digit_char(rem_nxt);

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		if (state_q == ST_RD) begin
			ram_re = 1'b1;
		end else if (state_q == ST_OUT && out_free && idx_q != '0) begin
			ram_re    = 1'b1;
			ram_raddr = idx_q - 1'b1;
		end
	end

	itoa_ram #(
		.WIDTH(8),
		.DEPTH(MAX_WIDTH)
	) u_digits (
		.clk  (clk),
		.we   (ram_we),
		.waddr(n_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
			m_tuser  <= 1'b0;
			v_q      <= '0;
			radix_q  <= '0;
			rem_q    <= '0;
			neg_q    <= 1'b0;
			top_q    <= '0;
			c_q      <= '0;
			n_q      <= '0;
			idx_q    <= '0;
		end else begin
			if (m_tvalid && m_tready && !out_load) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						v_q     <= cmd.value[VW-1:0];
						radix_q <= cmd.radix;
						neg_q   <= cmd.neg;
						rem_q   <= '0;
						n_q     <= '0;
						top_q   <= cmd.wide ? TOP_WIDE : TOP_NARROW;
						c_q     <= cmd.wide ? TOP_WIDE : TOP_NARROW;
						state_q <= cmd.bad ? ST_ERR : ST_DIV;
					end
				end
				ST_DIV: begin
					v_q <= v_nxt;
					if (c_q != '0) begin
						c_q   <= c_q - 1'b1;
						rem_q <= rem_nxt;
					end else begin
						rem_q <= '0;
						n_q   <= n_q + 1'b1;
						idx_q <= n_q;
						if (v_zero || n_q == LAST_ADDR) begin
							state_q <= neg_q ? ST_SIGN : ST_RD;
						end else begin
							top_q <= shrink ? top_q - 1'b1 : top_q;
							c_q   <= shrink ? top_q - 1'b1 : top_q;
						end
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= itoa_pkg::CHAR_MINUS;
						m_tlast  <= 1'b0;
						m_tuser  <= 1'b0;
						state_q  <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= ram_rdata;
						m_tlast  <= (idx_q == '0);
						m_tuser  <= 1'b0;
						if (idx_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q - 1'b1;
						end
					end
				end
				ST_ERR: begin
					if (out_free) begin
						m_tvalid <= 1'b1;
						m_tdata  <= itoa_pkg::CHAR_NONE;
						m_tlast  <= 1'b1;
						m_tuser  <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: src/integer_to_radix_ascii_core.sv
// Integer to ASCII in bases 2..36, most significant digit first, lower-case letters,
// a leading '-' only for negative signed values in base 10, one character per output
// item with tlast on the final one. A base outside 2..36 gives a single item with
// character 0 and tuser set. A two-entry queue sits between the input classifier and the
// converter. The converter divides by the base one byte of the value per cycle, from the
// current top byte down to byte 0. The top byte starts at byte 3 in 32-bit mode and at
// the top byte of MAX_WIDTH in wide mode, and drops by at most one byte per digit once
// the quotient's top byte goes to zero, so a small value in wide mode still walks its
// leading zero bytes. Digits are then read back from a digit memory at one character
// per cycle while the output is not stalled.
`include "integer_to_radix_ascii_core_macros.svh"

module integer_to_radix_ascii_core #(
	parameter int MAX_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // [63:0] number, [69:64] radix, [71:70] zero
	input  logic [1:0]  s_tuser,   // [0] is_signed, [1] is_wide
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] character
	output logic        m_tlast,
	output logic        m_tuser    // [0] bad_radix
);

	itoa_pkg::cmd_t front_cmd;
	itoa_pkg::cmd_t back_cmd;
	logic           front_valid;
	logic           front_ready;
	logic           back_valid;
	logic           back_ready;

	itoa_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (front_cmd),
		.cmd_valid(front_valid),
		.cmd_ready(front_ready)
	);

	itoa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(front_valid),
		.push_ready(front_ready),
		.push_cmd  (front_cmd),
		.pop_valid (back_valid),
		.pop_ready (back_ready),
		.pop_cmd   (back_cmd)
	);

	itoa_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (back_cmd),
		.cmd_valid(back_valid),
		.cmd_ready(back_ready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// error item is always a lone zero character
	`ITOA_ASSERT_SAME(a_err_item, clk, arst_n, m_tvalid && m_tuser,
		m_tlast && (m_tdata == itoa_pkg::CHAR_NONE))
	// a minus sign is never the final character
	`ITOA_ASSERT_SAME(a_minus_not_last, clk, arst_n,
		m_tvalid && (m_tdata == itoa_pkg::CHAR_MINUS), !m_tlast && !m_tuser)
	// ordinary characters are never zero
	`ITOA_ASSERT_SAME(a_char_nonzero, clk, arst_n, m_tvalid && !m_tuser,
		m_tdata != itoa_pkg::CHAR_NONE)
	// the back end is busy in the cycle after it takes a queued item
	`ITOA_ASSERT_NEXT(a_queue_pop, clk, arst_n, back_valid && back_ready, !back_ready)

endmodule
